// File: sv/vfa_pkg.sv
// Package for the three-component vector ALU: widths, operation codes,
// the pipeline carry record and the saturation helper. No dependencies.
`default_nettype none

package vfa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_W      = 4;
  localparam int LANES     = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PRE_W     = PROD_W + 2;
  localparam int RAD_W     = PROD_W;
  localparam int SQ_N      = DATA_W;
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int LATENCY   = SQ_N + DIV_W + 5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic        [DATA_W-1:0] uword_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PRE_W-1:0]  pre_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_DIVS  = 4'd5,
    OP_MAG   = 4'd6,
    OP_MAGSQ = 4'd7,
    OP_DOT   = 4'd8,
    OP_CROSS = 4'd9,
    OP_NORM  = 4'd10
  } op_t;

  // Record that rides along the square-root and divider stages.
  // r holds the finished vector, or the dividend for divide-type operations.
  typedef struct packed {
    op_t                    op;
    logic [LANES-1:0][DATA_W-1:0] r;
    logic [LANES-1:0][DATA_W-1:0] d;
    word_t                  sc;
    logic                   ov;
  } carry_t;

  typedef struct packed {
    word_t val;
    logic  ov;
  } sat_t;

  function automatic sat_t saturate(pre_t v);
    sat_t s;
    if (v > pre_t'(WORD_MAX)) begin
      s.val = WORD_MAX;
      s.ov  = 1'b1;
    end else if (v < pre_t'(WORD_MIN)) begin
      s.val = WORD_MIN;
      s.ov  = 1'b1;
    end else begin
      s.val = v[DATA_W-1:0];
      s.ov  = 1'b0;
    end
    return s;
  endfunction

  function automatic logic is_div_op(op_t op);
    logic res;
    case (op)
      OP_DIV, OP_DIVS, OP_NORM: res = 1'b1;
      default:                  res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic uword_t abs_word(word_t x);
    return uword_t'(x[DATA_W-1] ? -x : x);
  endfunction

endpackage

`default_nettype wire

// File: sv/vec3_fixed_point_alu.sv
// Top level of the three-component fixed-point vector ALU: multiply front end,
// pipelined square root and pipelined restoring divider. Depends on vfa_pkg.
`default_nettype none

// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+---------------------------
// input    | in_operation, in_ax..in_bz, in_scalar_in      | start high, busy low
// result   | out_rx, out_ry, out_rz, out_scalar_out, flags | out_valid high, one cycle
//
// One item enters per cycle; busy stays low, the pipeline never stalls.
// Each result passes, at 16 fraction bits, through three front-end stages, one
// square-root stage per result bit (32), one divider entry stage, one divider
// stage per quotient bit (48) and one output stage.
// Every operation runs the full depth so results leave in order.
// Synchronous reset clears the valid chain only; payload registers are not reset.
module vec3_fixed_point_alu (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [vfa_pkg::OP_W-1:0]          in_operation,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_ax,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_ay,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_az,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_bx,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_by_comp,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_bz,
  input  wire logic signed [vfa_pkg::DATA_W-1:0] in_scalar_in,
  output logic                                   out_valid,
  output logic signed [vfa_pkg::DATA_W-1:0]      out_rx,
  output logic signed [vfa_pkg::DATA_W-1:0]      out_ry,
  output logic signed [vfa_pkg::DATA_W-1:0]      out_rz,
  output logic signed [vfa_pkg::DATA_W-1:0]      out_scalar_out,
  output logic                                   out_overflow_flag,
  output logic                                   out_div_zero_flag
);
  import vfa_pkg::*;

  logic  in_acc;
  op_t   op_in;
  word_t a_in [LANES];
  word_t b_in [LANES];

  // Stage 1: products
  logic  s1_vld_r;
  op_t   s1_op_r;
  word_t s1_a_r [LANES];
  word_t s1_b_r [LANES];
  word_t s1_d_r [LANES];
  prod_t s1_p_r [LANES];
  prod_t s1_q_r [LANES];

  // Stage 2: sums and shifts before saturation
  logic  s2_vld_r;
  op_t   s2_op_r;
  word_t s2_a_r [LANES];
  word_t s2_d_r [LANES];
  pre_t  s2_pre_r [LANES];
  pre_t  s2_sum_r;

  // Square-root chain, index 0 is the stage-3 register
  logic   [SQ_N:0]     sq_vld_r;
  carry_t              sq_c_r    [SQ_N+1];
  logic   [RAD_W-1:0]  sq_rad_r  [SQ_N+1];
  logic   [DATA_W+1:0] sq_rem_r  [SQ_N+1];
  uword_t              sq_root_r [SQ_N+1];
  carry_t              c3_nxt;

  // Divider chain, index 0 is the entry register
  logic   [DIV_W:0]    dv_vld_r;
  carry_t              dv_c_r   [DIV_W+1];
  uword_t              dv_rem_r [DIV_W+1][LANES];
  logic   [DIV_W-1:0]  dv_nq_r  [DIV_W+1][LANES];
  uword_t              dv_den_r [DIV_W+1][LANES];
  logic                dv_neg_r [DIV_W+1][LANES];
  carry_t              dv0_c_nxt;

  // Output registers
  logic  out_valid_r;
  op_t   out_op_r;
  word_t out_r_r [LANES];
  word_t out_r_nxt [LANES];
  word_t out_sc_r;
  logic  out_ov_r, out_ov_nxt;
  logic  out_dz_r, out_dz_nxt;

  // No stall source downstream, so the input side is always open.
  assign busy   = 1'b0;
  assign in_acc = start && !busy;
  assign op_in  = op_t'(in_operation);

  assign a_in[0] = in_ax;
  assign a_in[1] = in_ay;
  assign a_in[2] = in_az;
  assign b_in[0] = in_bx;
  assign b_in[1] = in_by_comp;
  assign b_in[2] = in_bz;

  // Valid chain: advance every cycle, clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      sq_vld_r    <= '0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= in_acc;
      s2_vld_r    <= s1_vld_r;
      sq_vld_r    <= {sq_vld_r[SQ_N-1:0], s2_vld_r};
      dv_vld_r    <= {dv_vld_r[DIV_W-1:0], sq_vld_r[SQ_N]};
      out_valid_r <= dv_vld_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= op_in;
    s2_op_r <= s1_op_r;
  end

  // Front end, one lane per component. Cross product uses the second
  // multiplier of each lane; all other operations leave it at zero.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int I1 = (i + 1) % LANES;
    localparam int I2 = (i + 2) % LANES;
    word_t mx, my, nx, ny;
    pre_t  pre_nxt;
    pre_t  cross_diff;

    always_comb begin
      mx = a_in[i];
      my = b_in[i];
      nx = '0;
      ny = '0;
      case (op_in)
        OP_CROSS: begin
          mx = a_in[I1];
          my = b_in[I2];
          nx = a_in[I2];
          ny = b_in[I1];
        end
        OP_SCALE:                  my = in_scalar_in;
        OP_MAG, OP_MAGSQ, OP_NORM: my = a_in[i];
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      s1_a_r[i] <= a_in[i];
      s1_b_r[i] <= b_in[i];
      s1_d_r[i] <= (op_in == OP_DIV) ? b_in[i] : in_scalar_in;
      s1_p_r[i] <= prod_t'(mx) * prod_t'(my);
      s1_q_r[i] <= prod_t'(nx) * prod_t'(ny);
    end

    // Floor shift is an arithmetic right shift of the exact value.
    always_comb begin
      cross_diff = pre_t'(s1_p_r[i]) - pre_t'(s1_q_r[i]);
      case (s1_op_r)
        OP_ADD:           pre_nxt = pre_t'(s1_a_r[i]) + pre_t'(s1_b_r[i]);
        OP_SUB:           pre_nxt = pre_t'(s1_a_r[i]) - pre_t'(s1_b_r[i]);
        OP_MUL, OP_SCALE: pre_nxt = pre_t'(s1_p_r[i] >>> FRAC_BITS);
        OP_CROSS:         pre_nxt = cross_diff >>> FRAC_BITS;
        default:          pre_nxt = '0;
      endcase
    end

    always_ff @(posedge clk) begin
      s2_a_r[i]   <= s1_a_r[i];
      s2_d_r[i]   <= s1_d_r[i];
      s2_pre_r[i] <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r <= pre_t'(s1_p_r[0]) + pre_t'(s1_p_r[1]) + pre_t'(s1_p_r[2]);
  end

  // Stage 3: saturate the direct results, hand dividends and the radicand on.
  always_comb begin
    sat_t ls;
    sat_t ss;
    c3_nxt    = '0;
    c3_nxt.op = s2_op_r;
    for (int i = 0; i < LANES; i++) begin
      ls = saturate(s2_pre_r[i]);
      c3_nxt.r[i] = is_div_op(s2_op_r) ? s2_a_r[i] : ls.val;
      c3_nxt.d[i] = s2_d_r[i];
      c3_nxt.ov   = c3_nxt.ov | ls.ov;
    end
    ss = saturate(s2_sum_r >>> FRAC_BITS);
    if (s2_op_r == OP_MAGSQ || s2_op_r == OP_DOT) begin
      c3_nxt.sc = ss.val;
      c3_nxt.ov = c3_nxt.ov | ss.ov;
    end
  end

  always_ff @(posedge clk) begin
    sq_c_r[0]    <= c3_nxt;
    sq_rad_r[0]  <= s2_sum_r[RAD_W-1:0];
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  // Square root: one result bit per stage, two radicand bits consumed.
  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [DATA_W+3:0] rem_t, trial, diff;
    logic              ge;

    always_comb begin
      rem_t = {sq_rem_r[k], sq_rad_r[k][RAD_W-1 -: 2]};
      trial = {2'b00, sq_root_r[k], 2'b01};
      ge    = (rem_t >= trial);
      diff  = rem_t - trial;
    end

    always_ff @(posedge clk) begin
      sq_c_r[k+1]    <= sq_c_r[k];
      sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
      sq_rem_r[k+1]  <= ge ? diff[DATA_W+1:0] : rem_t[DATA_W+1:0];
      sq_root_r[k+1] <= {sq_root_r[k][DATA_W-2:0], ge};
    end
  end

  // Divider entry: finish magnitude, pick divisors, split signs off.
  always_comb begin
    uword_t root;
    root      = sq_root_r[SQ_N];
    dv0_c_nxt = sq_c_r[SQ_N];
    if (dv0_c_nxt.op == OP_MAG) begin
      dv0_c_nxt.sc = root[DATA_W-1] ? WORD_MAX : word_t'(root);
      dv0_c_nxt.ov = dv0_c_nxt.ov | root[DATA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_c_r[0] <= dv0_c_nxt;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_dv0
    word_t av, dw;
    always_comb begin
      av = sq_c_r[SQ_N].r[i];
      dw = sq_c_r[SQ_N].d[i];
    end
    always_ff @(posedge clk) begin
      dv_rem_r[0][i] <= '0;
      dv_nq_r[0][i]  <= {abs_word(av), {FRAC_BITS{1'b0}}};
      if (sq_c_r[SQ_N].op == OP_NORM) begin
        dv_den_r[0][i] <= sq_root_r[SQ_N];
        dv_neg_r[0][i] <= av[DATA_W-1];
      end else begin
        dv_den_r[0][i] <= abs_word(dw);
        dv_neg_r[0][i] <= av[DATA_W-1] ^ dw[DATA_W-1];
      end
    end
  end

  // Restoring divider: one quotient bit per stage, dividend bits shift out
  // the top of nq while quotient bits shift in at the bottom.
  for (genvar k = 0; k < DIV_W; k++) begin : g_dv
    always_ff @(posedge clk) begin
      dv_c_r[k+1] <= dv_c_r[k];
    end
    for (genvar i = 0; i < LANES; i++) begin : g_ln
      logic [DATA_W:0] rem_t, diff;
      logic            ge;
      always_comb begin
        rem_t = {dv_rem_r[k][i], dv_nq_r[k][i][DIV_W-1]};
        ge    = (rem_t >= {1'b0, dv_den_r[k][i]});
        diff  = rem_t - {1'b0, dv_den_r[k][i]};
      end
      always_ff @(posedge clk) begin
        dv_rem_r[k+1][i] <= ge ? diff[DATA_W-1:0] : rem_t[DATA_W-1:0];
        dv_nq_r[k+1][i]  <= {dv_nq_r[k][i][DIV_W-2:0], ge};
        dv_den_r[k+1][i] <= dv_den_r[k][i];
        dv_neg_r[k+1][i] <= dv_neg_r[k][i];
      end
    end
  end

  // Output stage: sign the quotients, handle zero divisors, merge flags.
  always_comb begin
    carry_t c;
    word_t  av;
    pre_t   q;
    sat_t   qs;
    c          = dv_c_r[DIV_W];
    out_ov_nxt = c.ov;
    out_dz_nxt = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      av = c.r[i];
      q  = pre_t'(dv_nq_r[DIV_W][i]);
      qs = saturate(dv_neg_r[DIV_W][i] ? -q : q);
      if (!is_div_op(c.op)) begin
        out_r_nxt[i] = av;
      end else if (dv_den_r[DIV_W][i] == '0) begin
        out_dz_nxt = 1'b1;
        if (c.op == OP_NORM || av == '0) begin
          out_r_nxt[i] = '0;
        end else begin
          out_r_nxt[i] = av[DATA_W-1] ? WORD_MIN : WORD_MAX;
        end
      end else begin
        out_r_nxt[i] = qs.val;
        out_ov_nxt   = out_ov_nxt | qs.ov;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_op_r <= dv_c_r[DIV_W].op;
    out_r_r  <= out_r_nxt;
    out_sc_r <= dv_c_r[DIV_W].sc;
    out_ov_r <= out_ov_nxt;
    out_dz_r <= out_dz_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rx            = out_r_r[0];
  assign out_ry            = out_r_r[1];
  assign out_rz            = out_r_r[2];
  assign out_scalar_out    = out_sc_r;
  assign out_overflow_flag = out_ov_r;
  assign out_div_zero_flag = out_dz_r;

`ifndef SYNTHESIS
  // Zero-divisor flag only comes from the divide-type operations.
  a_dz_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero_flag |->
      (out_op_r == OP_DIV || out_op_r == OP_DIVS || out_op_r == OP_NORM))
    else $error("div_zero_flag on a non-divide operation");

  // A unit vector never saturates.
  a_norm_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_r == OP_NORM |-> !out_overflow_flag)
    else $error("normalize raised overflow");

  // Scalar operations leave the vector at zero.
  a_scalar_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op_r == OP_MAG || out_op_r == OP_MAGSQ || out_op_r == OP_DOT) |->
      (out_rx == '0 && out_ry == '0 && out_rz == '0))
    else $error("scalar operation with nonzero vector");

  // Vector operations leave the scalar at zero.
  a_vec_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op_r == OP_ADD || out_op_r == OP_CROSS || out_op_r == OP_NORM) |->
      out_scalar_out == '0)
    else $error("vector operation with nonzero scalar");
`endif

endmodule

`default_nettype wire
